// ===== design/assert_macros.svh =====
// Assertion macros shared by the calendar date counter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check that a property holds on every rising clock edge outside reset.
`define CDC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
// Check that an expression is never true outside reset.
`define CDC_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("forbidden condition seen");
`else
`define CDC_ASSERT(lbl, clk, rstn, prop)
`define CDC_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ===== design/cdc_pkg.sv =====
// Types, constants and calendar helper functions of the date counter.
`timescale 1ns / 1ps
`default_nettype none

package cdc_pkg;

  // Fixed field widths of the request and result channels
  localparam int unsigned DAY_IN_W  = 6;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned YEAR_IO_W = 16;
  localparam int unsigned COUNT_IO_W = 10;
  localparam int unsigned DAY_W     = 5;
  localparam int unsigned M400_W    = 9;

  typedef logic [DAY_W-1:0]   day_t;
  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [M400_W-1:0]  m400_t;

  localparam month_t MONTH_MIN = 4'd1;
  localparam month_t MONTH_MAX = 4'd12;
  localparam day_t   DAY_MIN   = 5'd1;
  localparam m400_t  M400_LAST = 9'd399;
  localparam logic [M400_W:0] M400_DIV = 10'd400;

  typedef enum logic [1:0] {
    FUNC_SET  = 2'd0,
    FUNC_PRE  = 2'd1,
    FUNC_POST = 2'd2,
    FUNC_ADD  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REM,
    ST_INC,
    ST_ADD,
    ST_EMIT
  } state_e;

  // Leap year from the year modulo 400
  function automatic logic is_leap(m400_t r);
    logic century;
    century = (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
    return (r[1:0] == 2'b00) && !century;
  endfunction

  // Length of a month; codes outside 1..12 read as 31
  function automatic day_t days_in(month_t m, logic leap);
    day_t len;
    unique case (m) inside
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== design/cdc_if.sv =====
// Request and result channel interfaces of the date counter.
`timescale 1ns / 1ps
`default_nettype none

interface cdc_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         func;
  logic [cdc_pkg::DAY_IN_W-1:0]       day_in;
  logic [cdc_pkg::MONTH_W-1:0]        month_in;
  logic [cdc_pkg::YEAR_IO_W-1:0]      year_in;
  logic [cdc_pkg::COUNT_IO_W-1:0]     day_count;

  modport source (output valid, func, day_in, month_in, year_in, day_count, input ready);
  modport sink   (input valid, func, day_in, month_in, year_in, day_count, output ready);
endinterface

interface cdc_out_if;
  logic                               valid;
  logic                               ready;
  logic [cdc_pkg::DAY_W-1:0]          day_out;
  logic [cdc_pkg::MONTH_W-1:0]        month_out;
  logic [cdc_pkg::YEAR_IO_W-1:0]      year_out;

  modport source (output valid, day_out, month_out, year_out, input ready);
  modport sink   (input valid, day_out, month_out, year_out, output ready);
endinterface

`default_nettype wire

// ===== design/cdc_rem400.sv =====
// Remainder unit: year modulo 400 by reciprocal multiplication in registered stages.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cdc_rem400 #(
  parameter int unsigned YEAR_WIDTH = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [YEAR_WIDTH-1:0] value_i,
  output logic                       done_o,
  output cdc_pkg::m400_t             rem_o
);

  // Quotient as (y * Recip) >> Shift: exact for every y below 2**YEAR_WIDTH, since
  // Recip * 400 exceeds 2**Shift by less than 2**9
  localparam int unsigned Shift  = YEAR_WIDTH + 9;
  localparam int unsigned RecipW = YEAR_WIDTH + 1;
  localparam int unsigned ProdW  = YEAR_WIDTH + RecipW;
  localparam int unsigned QuotW  = ProdW - Shift;
  localparam logic [63:0] Div64  = 64'(cdc_pkg::M400_DIV);
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << Shift) + Div64 - 64'd1) / Div64);

  logic                  val_ok_q;
  logic                  quot_ok_q;
  logic                  rem_ok_q;
  logic [YEAR_WIDTH-1:0] val_q;
  logic [QuotW-1:0]      quot_q;
  cdc_pkg::m400_t        rem_q;

  logic [ProdW-1:0]      prod;
  logic [QuotW-1:0]      quot_d;
  logic [YEAR_WIDTH-1:0] quot_ext;
  logic [YEAR_WIDTH-1:0] quot_x400;
  logic [YEAR_WIDTH-1:0] diff;
  cdc_pkg::m400_t        rem_d;

  // Quotient from the held year, then the remainder as year - 400 * quotient
  // (400 = 256 + 128 + 16)
  always_comb begin
    prod      = ProdW'(val_q) * ProdW'(Recip);
    quot_d    = prod[ProdW-1:Shift];
    quot_ext  = YEAR_WIDTH'(quot_q);
    quot_x400 = (quot_ext << 8) + (quot_ext << 7) + (quot_ext << 4);
    diff      = val_q - quot_x400;
    rem_d     = diff[cdc_pkg::M400_W-1:0];
  end

  // Advance the stage flags and hold the remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_ok_q  <= 1'b0;
      quot_ok_q <= 1'b0;
      rem_ok_q  <= 1'b0;
      rem_q     <= '0;
    end else begin
      val_ok_q  <= start_i;
      quot_ok_q <= val_ok_q;
      rem_ok_q  <= quot_ok_q;
      if (quot_ok_q) begin
        rem_q <= rem_d;
      end
    end
  end

  // Hold the year and its quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= value_i;
    end
    if (val_ok_q) begin
      quot_q <= quot_d;
    end
  end

  assign done_o = rem_ok_q;
  assign rem_o  = rem_q;

  `CDC_ASSERT(a_rem_range, clk_i, rst_ni, {1'b0, rem_q} < cdc_pkg::M400_DIV)
  `CDC_ASSERT(a_quot_fits, clk_i, rst_ni, quot_ok_q |-> quot_x400 <= val_q)
  `CDC_ASSERT(a_done_follows, clk_i, rst_ni, start_i |-> ##3 rem_ok_q)

endmodule

`default_nettype wire

// ===== design/cdc_next_day.sv =====
// Shared step unit: the calendar date one day later.
`timescale 1ns / 1ps
`default_nettype none

module cdc_next_day #(
  parameter int unsigned YEAR_WIDTH = 16
) (
  input  wire cdc_pkg::day_t         day_i,
  input  wire cdc_pkg::month_t       month_i,
  input  wire logic [YEAR_WIDTH-1:0] year_i,
  input  wire cdc_pkg::m400_t        m400_i,
  output cdc_pkg::day_t              day_o,
  output cdc_pkg::month_t            month_o,
  output logic [YEAR_WIDTH-1:0]      year_o,
  output cdc_pkg::m400_t             m400_o
);

  cdc_pkg::day_t dmax;

  // Roll day, then month, then year; the year residue follows the year
  always_comb begin
    dmax    = cdc_pkg::days_in(month_i, cdc_pkg::is_leap(m400_i));
    day_o   = day_i + 1'b1;
    month_o = month_i;
    year_o  = year_i;
    m400_o  = m400_i;
    if (day_i >= dmax) begin
      day_o   = cdc_pkg::DAY_MIN;
      month_o = month_i + 1'b1;
      if (month_i >= cdc_pkg::MONTH_MAX) begin
        month_o = cdc_pkg::MONTH_MIN;
        year_o  = year_i + 1'b1;
        if (&year_i) begin
          m400_o = '0;
        end else if (m400_i == cdc_pkg::M400_LAST) begin
          m400_o = '0;
        end else begin
          m400_o = m400_i + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/calendar_date_counter_unit.sv =====
// Top level: Gregorian date register with set, increment and add requests.
// Sequence after the accepting edge: increment passes INC and EMIT; add steps one day per
// cycle through the shared step unit while day_count runs down, then EMIT; set waits for
// the year modulo 400 (reciprocal multiplication in the remainder unit), then EMIT. Output
// stalls hold EMIT. One request is in work at a time; the next is taken in the cycle after
// the result enters the output register. Reset gives 1 January of year 0, no result pending.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module calendar_date_counter_unit #(
  parameter int unsigned YEAR_WIDTH  = 16,
  parameter int unsigned COUNT_WIDTH = 10
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cdc_in_if.sink     in_req_i,
  cdc_out_if.source  out_rsp_o
);

  cdc_pkg::state_e state_q, state_d;

  cdc_pkg::func_e         func_q;
  logic [COUNT_WIDTH-1:0] cnt_q;
  logic [cdc_pkg::DAY_IN_W-1:0] set_day_q;
  cdc_pkg::month_t        set_month_q;

  cdc_pkg::day_t          cur_day_q;
  cdc_pkg::month_t        cur_month_q;
  logic [YEAR_WIDTH-1:0]  cur_year_q;
  cdc_pkg::m400_t         cur_m400_q;

  cdc_pkg::day_t          res_day_q;
  cdc_pkg::month_t        res_month_q;
  logic [YEAR_WIDTH-1:0]  res_year_q;
  cdc_pkg::m400_t         res_m400_q;

  logic                   out_valid_q;
  cdc_pkg::day_t          out_day_q;
  cdc_pkg::month_t        out_month_q;
  logic [cdc_pkg::YEAR_IO_W-1:0] out_year_q;

  logic accept, out_free, rem_done;
  logic in_ready, rem_start, do_inc, do_set, do_step, out_load;
  cdc_pkg::m400_t rem_val;

  cdc_pkg::day_t          nx_day;
  cdc_pkg::month_t        nx_month;
  logic [YEAR_WIDTH-1:0]  nx_year;
  cdc_pkg::m400_t         nx_m400;

  cdc_pkg::month_t        cl_month;
  cdc_pkg::day_t          cl_dmax;
  cdc_pkg::day_t          cl_day;

  assign accept   = in_req_i.valid && in_ready;
  assign out_free = !out_valid_q || out_rsp_o.ready;

  // Year modulo 400 for a new date
  cdc_rem400 #(
    .YEAR_WIDTH(YEAR_WIDTH)
  ) u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(rem_start),
    .value_i(YEAR_WIDTH'(in_req_i.year_in)),
    .done_o (rem_done),
    .rem_o  (rem_val)
  );

  // One day forward from the working date
  cdc_next_day #(
    .YEAR_WIDTH(YEAR_WIDTH)
  ) u_step (
    .day_i  (res_day_q),
    .month_i(res_month_q),
    .year_i (res_year_q),
    .m400_i (res_m400_q),
    .day_o  (nx_day),
    .month_o(nx_month),
    .year_o (nx_year),
    .m400_o (nx_m400)
  );

  // Clamp a requested month and day to a valid date
  always_comb begin
    if (set_month_q < cdc_pkg::MONTH_MIN) begin
      cl_month = cdc_pkg::MONTH_MIN;
    end else if (set_month_q > cdc_pkg::MONTH_MAX) begin
      cl_month = cdc_pkg::MONTH_MAX;
    end else begin
      cl_month = set_month_q;
    end
    cl_dmax = cdc_pkg::days_in(cl_month, cdc_pkg::is_leap(rem_val));
    if (set_day_q > {1'b0, cl_dmax}) begin
      cl_day = cl_dmax;
    end else if (set_day_q == '0) begin
      cl_day = cdc_pkg::DAY_MIN;
    end else begin
      cl_day = set_day_q[cdc_pkg::DAY_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cdc_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (cdc_pkg::func_e'(in_req_i.func)) inside
            cdc_pkg::FUNC_SET:                     state_d = cdc_pkg::ST_REM;
            cdc_pkg::FUNC_ADD:                     state_d = cdc_pkg::ST_ADD;
            cdc_pkg::FUNC_PRE, cdc_pkg::FUNC_POST: state_d = cdc_pkg::ST_INC;
            default:                               state_d = cdc_pkg::ST_INC;
          endcase
        end
      end
      cdc_pkg::ST_REM:  if (rem_done) state_d = cdc_pkg::ST_EMIT;
      cdc_pkg::ST_INC:  state_d = cdc_pkg::ST_EMIT;
      cdc_pkg::ST_ADD:  if (cnt_q == '0) state_d = cdc_pkg::ST_EMIT;
      cdc_pkg::ST_EMIT: if (out_free) state_d = cdc_pkg::ST_IDLE;
      default:          state_d = cdc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    rem_start = 1'b0;
    do_inc    = 1'b0;
    do_set    = 1'b0;
    do_step   = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      cdc_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        rem_start = in_req_i.valid &&
                    (cdc_pkg::func_e'(in_req_i.func) == cdc_pkg::FUNC_SET);
      end
      cdc_pkg::ST_REM:  do_set   = rem_done;
      cdc_pkg::ST_INC:  do_inc   = 1'b1;
      cdc_pkg::ST_ADD:  do_step  = (cnt_q != '0);
      cdc_pkg::ST_EMIT: out_load = out_free;
      default: ;
    endcase
  end

  assign in_req_i.ready = in_ready;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cdc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Stored date: advance on increment, replace on set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_day_q   <= cdc_pkg::DAY_MIN;
      cur_month_q <= cdc_pkg::MONTH_MIN;
      cur_year_q  <= '0;
      cur_m400_q  <= '0;
    end else if (do_set) begin
      cur_day_q   <= cl_day;
      cur_month_q <= cl_month;
      cur_year_q  <= res_year_q;
      cur_m400_q  <= rem_val;
    end else if (do_inc) begin
      cur_day_q   <= nx_day;
      cur_month_q <= nx_month;
      cur_year_q  <= nx_year;
      cur_m400_q  <= nx_m400;
    end
  end

  // Working date and request fields
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q      <= cdc_pkg::func_e'(in_req_i.func);
      cnt_q       <= COUNT_WIDTH'(in_req_i.day_count);
      set_day_q   <= in_req_i.day_in;
      set_month_q <= in_req_i.month_in;
      res_day_q   <= cur_day_q;
      res_month_q <= cur_month_q;
      res_m400_q  <= cur_m400_q;
      if (cdc_pkg::func_e'(in_req_i.func) == cdc_pkg::FUNC_SET) begin
        res_year_q <= YEAR_WIDTH'(in_req_i.year_in);
      end else begin
        res_year_q <= cur_year_q;
      end
    end else if (do_set) begin
      res_day_q   <= cl_day;
      res_month_q <= cl_month;
      res_m400_q  <= rem_val;
    end else if (do_step || (do_inc && (func_q == cdc_pkg::FUNC_PRE))) begin
      res_day_q   <= nx_day;
      res_month_q <= nx_month;
      res_year_q  <= nx_year;
      res_m400_q  <= nx_m400;
      if (do_step) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_day_q   <= res_day_q;
      out_month_q <= res_month_q;
      out_year_q  <= cdc_pkg::YEAR_IO_W'(res_year_q);
    end
  end

  assign out_rsp_o.valid     = out_valid_q;
  assign out_rsp_o.day_out   = out_day_q;
  assign out_rsp_o.month_out = out_month_q;
  assign out_rsp_o.year_out  = out_year_q;

  `CDC_ASSERT(a_cur_month, clk_i, rst_ni,
              cur_month_q >= cdc_pkg::MONTH_MIN && cur_month_q <= cdc_pkg::MONTH_MAX)
  `CDC_ASSERT(a_cur_day, clk_i, rst_ni,
              cur_day_q >= cdc_pkg::DAY_MIN &&
              cur_day_q <= cdc_pkg::days_in(cur_month_q, cdc_pkg::is_leap(cur_m400_q)))
  `CDC_ASSERT(a_add_keeps, clk_i, rst_ni,
              state_q == cdc_pkg::ST_ADD |=>
              $stable(cur_day_q) && $stable(cur_month_q) && $stable(cur_year_q))
  `CDC_ASSERT_NEVER(a_no_load_busy, clk_i, rst_ni,
                    out_load && out_valid_q && !out_rsp_o.ready)

endmodule

`default_nettype wire
